@@ hw/rtl/gaags_pkg.sv @@
// ----------------------------------------------------------------------------
// gaags_pkg: shared types and constants
// Sizes, input item codes, register indexes and the controller/datapath
// command and status structures for the alignment score unit.
// ----------------------------------------------------------------------------
`default_nettype none
package gaags_pkg;
  localparam int MaxQueryLen = 1024;
  localparam int MaxDbLen    = 65536;
  localparam int AlphaSize   = 32;
  localparam int QAW         = $clog2(MaxQueryLen);
  localparam int QLW         = $clog2(MaxQueryLen + 1);
  localparam int CIW         = $clog2(MaxDbLen + 1);
  localparam int SYW         = 5;
  localparam int TAW         = 2 * SYW;

  localparam logic [1:0] KindTable = 2'd0;
  localparam logic [1:0] KindQuery = 2'd1;
  localparam logic [1:0] KindDb    = 2'd2;

  localparam logic [0:0] RegGapOpen   = 1'd0;
  localparam logic [0:0] RegGapExtend = 1'd1;

  // Command from the controller to the datapath for one query position.
  typedef struct packed {
    logic           init;    // first column: set up H and E from the gaps
    logic           start;   // first query position of a column
    logic           step;    // a cell result is written back this cycle
    logic [QAW-1:0] pos;     // query position being read
    logic           rd;      // issue reads for pos
  } gaags_cmd_t;

  typedef struct packed {
    logic [31:0] h_last;
  } gaags_sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/gaags_ram.sv @@
// ----------------------------------------------------------------------------
// gaags_ram: generic single-port-write, registered-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module gaags_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/gaags_datapath.sv @@
// ----------------------------------------------------------------------------
// gaags_datapath: alignment cell and column memories
// Holds the score table, query, H and E columns and the running F and
// diagonal values; evaluates one query position per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gaags_datapath (
  input  wire logic                    clk,
  input  wire gaags_pkg::gaags_cmd_t   cmd,
  input  wire logic                    tbl_we,
  input  wire logic [gaags_pkg::TAW-1:0] tbl_addr,
  input  wire logic [7:0]              tbl_data,
  input  wire logic                    q_we,
  input  wire logic [gaags_pkg::QAW-1:0] q_addr,
  input  wire logic [4:0]              q_data,
  input  wire logic [4:0]              db_sym,
  input  wire logic [gaags_pkg::CIW-1:0] col_idx,
  input  wire logic signed [8:0]       gap_open,
  input  wire logic signed [8:0]       gap_extend,
  output gaags_pkg::gaags_sts_t        sts
);
  import gaags_pkg::*;

  logic [4:0]     qsym;
  logic [7:0]     tdat;
  logic [31:0]    h_rd, e_rd;
  logic [QAW-1:0] pos_d_r;
  logic           init_rd_r;
  logic           init_d_r;
  logic [31:0]    h_run_r, f_r, h_last_r;
  logic [31:0]    h_ini_r, e_ini_r;
  logic [31:0]    go_ext, ge_ext, goge;
  logic [31:0]    diag, e_in, h_cell, e_new, f_new, h_go;
  logic [31:0]    h_wr, e_wr;
  logic [31:0]    f_start, h_start;
  logic [31:0]    col_mul;
  logic [TAW-1:0] t_raddr;

  assign go_ext = {{23{gap_open[8]}}, gap_open};
  assign ge_ext = {{23{gap_extend[8]}}, gap_extend};
  assign goge   = go_ext + ge_ext;

  // Query symbol read at cmd.pos; the table is addressed with the registered
  // query symbol and the held database symbol.
  gaags_ram #(.Width(5), .Depth(MaxQueryLen)) u_query (
    .clk, .we(q_we), .waddr(q_addr), .wdata(q_data), .raddr(cmd.pos), .rdata(qsym)
  );

  assign t_raddr = {db_sym, qsym};
  // Table is read combinationally from the query read; registered inside.
  gaags_ram #(.Width(8), .Depth(AlphaSize * AlphaSize)) u_table (
    .clk, .we(tbl_we), .waddr(tbl_addr), .wdata(tbl_data), .raddr(t_raddr), .rdata(tdat)
  );

  // H and E are read at the registered position to line up with the table.
  logic [QAW-1:0] pos_rd_r;
  logic [31:0]    h_q, e_q;
  gaags_ram #(.Width(32), .Depth(MaxQueryLen)) u_hcol (
    .clk, .we(cmd.step), .waddr(pos_d_r), .wdata(h_wr), .raddr(pos_rd_r), .rdata(h_q)
  );
  gaags_ram #(.Width(32), .Depth(MaxQueryLen)) u_ecol (
    .clk, .we(cmd.step), .waddr(pos_d_r), .wdata(e_wr), .raddr(pos_rd_r), .rdata(e_q)
  );

  // On the first column the stored values are replaced by the boundary.
  assign h_rd = init_d_r ? h_ini_r : h_q;
  assign e_rd = init_d_r ? e_ini_r : e_q;
  assign diag = h_rd;
  assign e_in = e_rd;

  always_comb begin
    logic [31:0] hs;
    hs = h_run_r + {{24{tdat[7]}}, tdat};
    if (($signed(f_r) > $signed(hs))) hs = f_r;
    if (($signed(e_in) > $signed(hs))) hs = e_in;
    h_cell = hs;
  end
  assign h_go  = h_cell + goge;
  assign e_new = ($signed(e_in + ge_ext) < $signed(h_go)) ? h_go : e_in + ge_ext;
  assign f_new = ($signed(f_r + ge_ext) < $signed(h_go)) ? h_go : f_r + ge_ext;
  assign h_wr  = h_cell;
  assign e_wr  = e_new;

  // Boundary for column col_idx: H = go + j*ge (0 for j = 0),
  // F = 2*go + (j+2)*ge.
  assign col_mul = {{(32-CIW){1'b0}}, col_idx} * ge_ext;
  assign h_start = (col_idx == '0) ? 32'd0 : go_ext + col_mul;
  assign f_start = go_ext + go_ext + col_mul + ge_ext + ge_ext;

  always_ff @(posedge clk) begin
    pos_rd_r  <= cmd.pos;
    pos_d_r   <= pos_rd_r;
    init_rd_r <= cmd.init;
    init_d_r  <= init_rd_r;
    // Running boundary values for the first column, stepped by ge.
    if (cmd.rd && cmd.start) begin
      h_ini_r <= goge;
      e_ini_r <= go_ext + go_ext + ge_ext + ge_ext;
    end else if (cmd.step) begin
      h_ini_r <= h_ini_r + ge_ext;
      e_ini_r <= e_ini_r + ge_ext;
    end
    if (cmd.rd && cmd.start) begin
      h_run_r <= h_start;
      f_r     <= f_start;
    end else if (cmd.step) begin
      h_run_r  <= diag;
      f_r      <= f_new;
      h_last_r <= h_cell;
    end
  end

  assign sts.h_last = h_last_r;
endmodule
`default_nettype wire

@@ hw/rtl/gaags_ctrl.sv @@
// ----------------------------------------------------------------------------
// gaags_ctrl: sequencer for the alignment score unit
// Decodes items, keeps query length and column index, and sweeps the
// query positions for each database symbol.
// ----------------------------------------------------------------------------
`default_nettype none
module gaags_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_kind,
  input  wire logic                      in_last,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output gaags_pkg::gaags_cmd_t          cmd,
  output logic                           q_we,
  output logic [gaags_pkg::QAW-1:0]      q_addr,
  output logic [gaags_pkg::CIW-1:0]      col_idx,
  output logic                           res_load
);
  import gaags_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;
  logic [QLW-1:0] qlen_r, qlen_nxt;
  logic           qdone_r, qdone_nxt;
  logic [CIW-1:0] col_r, col_nxt;
  logic [QLW-1:0] pos_r, pos_nxt;
  logic           last_r, last_nxt;
  logic           init_r, init_nxt;
  logic [2:0]     pipe_r;
  logic           acc, db_go;
  logic [QLW-1:0] qbase;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign acc       = in_valid && in_ready;
  assign db_go     = acc && (in_kind == KindDb) && qdone_r && (qlen_r != '0);
  assign qbase     = qdone_r ? '0 : qlen_r;
  assign q_we      = acc && (in_kind == KindQuery) && (qbase < QLW'(MaxQueryLen));
  assign q_addr    = qbase[QAW-1:0];
  assign col_idx   = col_r;

  always_comb begin
    state_nxt = state_r;
    qlen_nxt  = qlen_r;
    qdone_nxt = qdone_r;
    col_nxt   = col_r;
    pos_nxt   = pos_r;
    last_nxt  = last_r;
    init_nxt  = init_r;
    res_load  = 1'b0;
    cmd       = '0;
    cmd.pos   = pos_r[QAW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (acc && in_kind == KindQuery) begin
          qlen_nxt  = q_we ? qbase + 1'b1 : qbase;
          qdone_nxt = in_last;
          col_nxt   = '0;
        end
        if (db_go) begin
          state_nxt = S_SWEEP;
          pos_nxt   = '0;
          last_nxt  = in_last;
          init_nxt  = (col_r == '0);
        end
      end
      S_SWEEP: begin
        cmd.rd    = 1'b1;
        cmd.start = (pos_r == '0);
        cmd.init  = init_r;
        pos_nxt   = pos_r + 1'b1;
        if (pos_r + 1'b1 == qlen_r) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (pipe_r == 3'b000) begin
          if (col_r != CIW'(MaxDbLen)) col_nxt = col_r + 1'b1;
          if (last_r) begin
            col_nxt   = '0;
            res_load  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // The cell fires once its read has passed through pipe_r[0] and pipe_r[1].
    cmd.step = pipe_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      qlen_r  <= '0;
      qdone_r <= 1'b0;
      col_r   <= '0;
      pos_r   <= '0;
      last_r  <= 1'b0;
      init_r  <= 1'b0;
      pipe_r  <= '0;
    end else begin
      state_r <= state_nxt;
      qlen_r  <= qlen_nxt;
      qdone_r <= qdone_nxt;
      col_r   <= col_nxt;
      pos_r   <= pos_nxt;
      last_r  <= last_nxt;
      init_r  <= init_nxt;
      pipe_r  <= {pipe_r[1:0], (state_r == S_SWEEP)};
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/global_alignment_affine_gap_score_unit.sv @@
// ----------------------------------------------------------------------------
// global_alignment_affine_gap_score_unit: affine-gap global alignment score
// Loads a score table and a query, then advances one matrix column per
// database symbol and returns the score at the final query position.
// ----------------------------------------------------------------------------
//  Channel | Direction | Carries
//  in_     | input     | one transaction: table write, query or database symbol
//  out_    | output    | one transaction: alignment_score after the last symbol
//  cfg_    | APB       | gap_open at 0x0, gap_extend at 0x4
//
// Table writes and query symbols are accepted back to back while idle.
// A database symbol holds the input while it is accepted, while the cell
// walks the H and E column RAMs one query position at a time, and while
// the read pipeline and the write-back drain.
// A marked last symbol then offers its result until out_ready takes it.
// Reset clears the controller, query length and gap registers; the RAMs are
// not cleared and the first column is built from the gaps on the fly.
// The input is stalled while a column sweeps or a result waits on out_ready.
`default_nettype none
module global_alignment_affine_gap_score_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_kind,
  input  wire logic [4:0]        in_symbol,
  input  wire logic [4:0]        in_partner_symbol,
  input  wire logic signed [7:0] in_score_value,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [31:0]     out_alignment_score,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import gaags_pkg::*;

  gaags_cmd_t     cmd;
  gaags_sts_t     sts;
  logic           q_we, res_load, tbl_we, cfg_wr;
  logic [QAW-1:0] q_addr;
  logic [CIW-1:0] col_idx;
  logic signed [8:0] gap_open_r, gap_extend_r;
  logic [4:0]     db_sym_r;
  logic [31:0]    score_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_open_r   <= '0;
      gap_extend_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegGapOpen:   gap_open_r   <= pwdata[8:0];
        RegGapExtend: gap_extend_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegGapOpen:   prdata = {{23{gap_open_r[8]}}, gap_open_r};
      RegGapExtend: prdata = {{23{gap_extend_r[8]}}, gap_extend_r};
      default:      prdata = '0;
    endcase
  end

  // The database symbol is held for the whole column sweep.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_kind == KindDb) db_sym_r <= in_symbol;
    if (res_load) score_r <= sts.h_last;
  end

  assign tbl_we = in_valid && in_ready && (in_kind == KindTable);
  assign out_alignment_score = score_r;

  gaags_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_last,
    .out_valid, .out_ready, .cmd, .q_we, .q_addr, .col_idx, .res_load
  );

  gaags_datapath u_dp (
    .clk, .cmd, .tbl_we, .tbl_addr({in_symbol, in_partner_symbol}),
    .tbl_data(in_score_value), .q_we, .q_addr, .q_data(in_symbol),
    .db_sym(db_sym_r), .col_idx, .gap_open(gap_open_r),
    .gap_extend(gap_extend_r), .sts
  );

  // No input is taken while a result waits.
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input accepted with result pending");
  // A result stays until it is taken.
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_alignment_score))
    else $error("result dropped");
  // A table write never coincides with a column write-back.
  a_tbl_idle: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> !cmd.step) else $error("table written during a sweep");
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the affine-gap alignment score unit
// Loads a score table and queries, streams database sequences through the
// block, and checks every alignment_score result against a predictor
// that keeps its own copy of the table, the query and the H/E columns.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import gaags_pkg::*;

  // Tracks the block's alignment state and holds the scores still owed.
  class score_tracker;
    logic signed [7:0] tbl [AlphaSize*AlphaSize];
    logic [4:0]        qsym [MaxQueryLen];
    int                h_col [MaxQueryLen];
    int                e_col [MaxQueryLen];
    int                qlen;
    int                col;
    bit                q_done;
    logic signed [8:0] gap_open;
    logic signed [8:0] gap_ext;
    int                expected_scores [$];
    int                n_fail;
    int                n_checked;

    function void set_gaps(logic signed [8:0] go, logic signed [8:0] ge);
      gap_open = go;
      gap_ext  = ge;
    endfunction

    // Applies one accepted input transaction to the predicted state.
    function void note_input(logic [1:0] kind, logic [4:0] sym, logic [4:0] partner,
                             logic signed [7:0] sv, logic last);
      longint go, ge, h, f, e, diag, j;
      go = gap_open;
      ge = gap_ext;
      case (kind)
        KindTable: tbl[{sym, partner}] = sv;
        KindQuery: begin
          if (q_done) begin
            qlen   = 0;
            q_done = 0;
          end
          col = 0;
          if (qlen < MaxQueryLen) begin
            qsym[qlen] = sym;
            qlen++;
          end
          if (last) q_done = 1;
        end
        KindDb: begin
          if (!q_done || qlen == 0) return;
          if (col == 0) begin
            for (int i = 0; i < qlen; i++) begin
              h_col[i] = int'(go + (i + 1) * ge);
              e_col[i] = int'(2 * go + (i + 2) * ge);
            end
          end
          j = col;
          f = 2 * go + (j + 2) * ge;
          h = (j == 0) ? 0 : go + j * ge;
          for (int i = 0; i < qlen; i++) begin
            diag = h_col[i];
            e    = e_col[i];
            h   += tbl[{sym, qsym[i]}];
            if (f > h) h = f;
            if (e > h) h = e;
            h_col[i] = int'(h);
            h  = h_col[i];
            e += ge;
            f += ge;
            h += go + ge;
            if (f < h) f = h;
            if (e < h) e = h;
            e_col[i] = int'(e);
            h = diag;
          end
          if (col < MaxDbLen) col++;
          if (last) begin
            expected_scores.push_back(h_col[qlen-1]);
            col = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [31:0] score);
      int want;
      if (expected_scores.size() == 0) begin
        $error("alignment_score: no result expected, actual %0d", score);
        n_fail++;
        return;
      end
      want = expected_scores.pop_front();
      n_checked++;
      if (score !== want) begin
        $error("alignment_score: expected %0d, actual %0d", want, score);
        n_fail++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_kind = KindTable;
  logic [4:0]        in_symbol = '0;
  logic [4:0]        in_partner_symbol = '0;
  logic signed [7:0] in_score_value = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [31:0] out_alignment_score;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  score_tracker tracker;
  bit           idle_on = 1'b1;   // random gaps and stalls allowed
  int           n_items;
  int           stall_left;

  global_alignment_affine_gap_score_unit u_top (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: mostly ready, with short and occasional long stalls.
  always @(posedge clk) begin
    if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 9) < 3) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Results are compared at the edge at which they are accepted.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_alignment_score);
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Alignment symbols come from a small set whose table entries are all written.
  function automatic logic [4:0] pick_sym();
    int k;
    k = $urandom_range(0, 7);
    return (k == 7) ? 5'd31 : 5'(k);
  endfunction

  // Sends one transaction; valid stays up from one item to the next unless
  // a gap is inserted, so the valid line sees one assignment per edge.
  task automatic send_item(logic [1:0] kind, logic [4:0] sym, logic [4:0] partner,
                           logic signed [7:0] sv, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= kind;
    in_symbol         <= sym;
    in_partner_symbol <= partner;
    in_score_value    <= sv;
    in_last           <= last;
    do @(posedge clk); while (!in_ready);
    tracker.note_input(kind, sym, partner, sv, last);
    n_items++;
  endtask

  // Lowers valid, then waits for every owed result plus the sweep latency,
  // since a database symbol with no result may still be in the column.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_scores.size() != 0) @(posedge clk);
    repeat (tracker.qlen + 10) @(posedge clk);
  endtask

  // Two back-to-back APB writes; the bus returns to idle after the second.
  task automatic write_gaps(logic signed [8:0] go, logic signed [8:0] ge);
    wait_idle();
    for (int r = 0; r < 2; r++) begin
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= (r == 0) ? 3'(4 * RegGapOpen) : 3'(4 * RegGapExtend);
      pwdata  <= (r == 0) ? 32'(go) : 32'(ge);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_gaps(go, ge);
  endtask

  task automatic send_query(int len);
    for (int i = 0; i < len; i++)
      send_item(KindQuery, pick_sym(), 5'($urandom), 8'($urandom), i == len - 1);
  endtask

  task automatic send_db(int len, bit mark_last);
    for (int i = 0; i < len; i++)
      send_item(KindDb, pick_sym(), 5'($urandom), 8'($urandom),
                mark_last && i == len - 1);
  endtask

  initial begin
    tracker = new();
    tracker.set_gaps(0, 0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A database symbol before any query is complete is simply dropped.
    send_item(KindDb, 5'd3, 5'd0, 8'sd0, 1'b1);
    send_item(2'd3, 5'd31, 5'd31, -8'sd1, 1'b1);

    // Fill every table entry that an alignment can read.
    for (int a = 0; a < 8; a++)
      for (int b = 0; b < 8; b++)
        send_item(KindTable, (a == 7) ? 5'd31 : 5'(a), (b == 7) ? 5'd31 : 5'(b),
                  8'($urandom), 1'($urandom));
    send_item(KindTable, 5'd0, 5'd0, -8'sd128, 1'b0);
    send_item(KindTable, 5'd31, 5'd31, 8'sd127, 1'b1);

    // Directed: zero gaps, one-symbol then two-symbol query and database.
    send_item(KindQuery, 5'd0, 5'd0, 8'sd0, 1'b1);
    send_item(KindDb, 5'd0, 5'd0, 8'sd0, 1'b1);
    send_item(KindQuery, 5'd31, 5'd0, 8'sd0, 1'b0);
    send_item(KindQuery, 5'd0, 5'd0, 8'sd0, 1'b1);
    send_item(KindDb, 5'd31, 5'd0, 8'sd0, 1'b0);
    send_item(KindDb, 5'd0, 5'd0, 8'sd0, 1'b1);
    // Extreme gap settings in both directions.
    write_gaps(-9'sd255, -9'sd255);
    send_db(3, 1'b1);
    write_gaps(9'sd255, 9'sd255);
    send_db(2, 1'b1);
    write_gaps(-9'sd11, -9'sd1);
    // A query symbol in the middle of a database sequence abandons it.
    send_db(2, 1'b0);
    send_query(3);
    send_db(4, 1'b1);

    // Over-long query: symbols beyond the query memory are dropped.
    idle_on = 1'b0;
    send_query(MaxQueryLen + 3);
    send_db(2, 1'b1);
    idle_on = 1'b1;

    // Random: mostly well-formed query/database sequences.
    while (n_items < 2000) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        write_gaps(9'($urandom_range(0, 510) - 255), 9'($urandom_range(0, 510) - 255));
      end else if (pick < 20) begin
        send_query(($urandom_range(0, 9) == 0) ? $urandom_range(20, 48)
                                               : $urandom_range(1, 10));
      end else if (pick < 25) begin
        send_item(KindTable, 5'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 27) begin
        send_item(2'd3, 5'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 30) begin
        send_db($urandom_range(1, 6), 1'b0);
      end else begin
        send_db(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                            : $urandom_range(1, 8), 1'b1);
      end
    end

    // Drain, then allow one full column sweep before the verdict.
    wait_idle();
    $display("Covered %0d input transactions and %0d alignment scores,",
             n_items, tracker.n_checked);
    $display("including extreme gaps, an over-long query, abandoned sequences and noise.");
    if (tracker.n_fail == 0 && tracker.expected_scores.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/gaags_pkg.sv
hw/rtl/gaags_ram.sv
hw/rtl/gaags_datapath.sv
hw/rtl/gaags_ctrl.sv
hw/rtl/global_alignment_affine_gap_score_unit.sv
tb/tb_top.sv
